// ===== sv/yuy2_to_rgb565_converter_assert.svh =====
// Assertion macros shared by the checker of the YUY2 to RGB565 converter.
// No dependencies; include by bare file name.
`ifndef YUY2_TO_RGB565_CONVERTER_ASSERT_SVH
`define YUY2_TO_RGB565_CONVERTER_ASSERT_SVH

// Same-cycle implication: when a holds, c must hold on that edge.
`define Y2R_ASSERT_IMPLY(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error(msg);

// Next-cycle implication: when a holds, c must hold on the following edge.
`define Y2R_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error(msg);

`endif

// ===== sv/y2r_pkg.sv =====
// Shared types and constants for the YUY2 to RGB565 converter.
// No dependencies.
package y2r_pkg;

  // Offsets removed from the incoming bytes.
  localparam int LUMA_OFFSET   = 16;
  localparam int CHROMA_OFFSET = 128;

  // Color coefficients in thousandths; scaled to fixed point at elaboration.
  localparam int COEF_RV_MILLI = 1140;
  localparam int COEF_GU_MILLI = 395;
  localparam int COEF_GV_MILLI = 581;
  localparam int COEF_BU_MILLI = 2032;
  localparam int MILLI         = 1000;

  // Largest channel value after flooring.
  localparam logic [7:0] CHAN_MAX = 8'hFF;

  // Load enables for the two register stages inside a pixel unit.
  typedef struct packed {
    logic sum_en;
    logic pack_en;
  } stage_en_t;

endpackage

// ===== sv/yuy2_to_rgb565_converter.sv =====
// Top level of the YUY2 to RGB565 converter: offset, multiply, sum, pack.
// Depends on y2r_pkg and y2r_pixel.
//
//   channel | signals                                          | role
//   --------+--------------------------------------------------+-----------------
//   yuv     | yuv_valid, yuv_ready, luma_first, chroma_blue,   | one macropixel in
//           | luma_second, chroma_red                          |
//   rgb     | rgb_valid, rgb_ready, pixel_first, pixel_second  | two pixels out
//
// One item per cycle sustained while rgb_ready is high; four register stages
// (offset removal, constant multiplies, channel sums, clamp/pack) lie between
// the accepting edge and rgb_valid, in that order.
// Reset clears the four stage valid bits; payload registers are not reset.
// A stall on rgb_ready backs up stage by stage: a stage loads whenever it is
// empty or its successor loads, so bubbles are squeezed out and nothing is
// lost or repeated.
module yuy2_to_rgb565_converter #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        yuv_valid,
  output logic        yuv_ready,
  input  logic [7:0]  luma_first,
  input  logic [7:0]  chroma_blue,
  input  logic [7:0]  luma_second,
  input  logic [7:0]  chroma_red,
  output logic        rgb_valid,
  input  logic        rgb_ready,
  output logic [15:0] pixel_first,
  output logic [15:0] pixel_second
);
  import y2r_pkg::*;

  // Accumulator width covers luma << frac plus the largest chroma product.
  localparam int ACC_W  = COEF_FRAC_BITS + 11;
  localparam int COEF_W = COEF_FRAC_BITS + 2;

  // Coefficients rounded to nearest in fixed point.
  localparam int COEF_RV_I =
    (COEF_RV_MILLI * (1 << COEF_FRAC_BITS) + MILLI / 2) / MILLI;
  localparam int COEF_GU_I =
    (COEF_GU_MILLI * (1 << COEF_FRAC_BITS) + MILLI / 2) / MILLI;
  localparam int COEF_GV_I =
    (COEF_GV_MILLI * (1 << COEF_FRAC_BITS) + MILLI / 2) / MILLI;
  localparam int COEF_BU_I =
    (COEF_BU_MILLI * (1 << COEF_FRAC_BITS) + MILLI / 2) / MILLI;

  // Zero-extend each unsigned coefficient to the signed accumulator width.
  localparam logic signed [ACC_W-1:0] COEF_RV =
    $signed({{(ACC_W-COEF_W){1'b0}}, COEF_W'(COEF_RV_I)});
  localparam logic signed [ACC_W-1:0] COEF_GU =
    $signed({{(ACC_W-COEF_W){1'b0}}, COEF_W'(COEF_GU_I)});
  localparam logic signed [ACC_W-1:0] COEF_GV =
    $signed({{(ACC_W-COEF_W){1'b0}}, COEF_W'(COEF_GV_I)});
  localparam logic signed [ACC_W-1:0] COEF_BU =
    $signed({{(ACC_W-COEF_W){1'b0}}, COEF_W'(COEF_BU_I)});

  // Stage valid bits and per-stage load conditions.
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  // Stage 1: bytes with offsets removed, 9-bit signed.
  logic signed [8:0] y0_s1, y1_s1, u_s1, v_s1;
  logic signed [ACC_W-1:0] u_ext, v_ext;

  // Stage 2: scaled luma and chroma products.
  logic signed [ACC_W-1:0] y0_scaled, y1_scaled;
  logic signed [ACC_W-1:0] prod_rv, prod_gu, prod_gv, prod_bu;

  stage_en_t pix_en;

  // Ready ripples back from the output: a stage takes new data if empty
  // or if its contents move on this cycle.
  always_comb begin
    s4_ready = !s4_valid || rgb_ready;
    s3_ready = !s3_valid || s4_ready;
    s2_ready = !s2_valid || s3_ready;
    s1_ready = !s1_valid || s2_ready;
    yuv_ready = s1_ready;
    rgb_valid = s4_valid;
    pix_en.sum_en  = s3_ready && s2_valid;
    pix_en.pack_en = s4_ready && s3_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= yuv_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
    end
  end

  // Stage 1: remove luma and chroma offsets.
  always_ff @(posedge clk) begin
    if (s1_ready && yuv_valid) begin
      y0_s1 <= $signed({1'b0, luma_first})  - $signed(9'(LUMA_OFFSET));
      y1_s1 <= $signed({1'b0, luma_second}) - $signed(9'(LUMA_OFFSET));
      u_s1  <= $signed({1'b0, chroma_blue}) - $signed(9'(CHROMA_OFFSET));
      v_s1  <= $signed({1'b0, chroma_red})  - $signed(9'(CHROMA_OFFSET));
    end
  end

  // Sign-extend chroma for the constant multiplies.
  always_comb begin
    u_ext = $signed({{(ACC_W-9){u_s1[8]}}, u_s1});
    v_ext = $signed({{(ACC_W-9){v_s1[8]}}, v_s1});
  end

  // Stage 2: shared chroma products, luma shifted into the fixed-point grid.
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      y0_scaled <= $signed({{(ACC_W-9-COEF_FRAC_BITS){y0_s1[8]}}, y0_s1,
                            {COEF_FRAC_BITS{1'b0}}});
      y1_scaled <= $signed({{(ACC_W-9-COEF_FRAC_BITS){y1_s1[8]}}, y1_s1,
                            {COEF_FRAC_BITS{1'b0}}});
      prod_rv   <= COEF_RV * v_ext;
      prod_gu   <= COEF_GU * u_ext;
      prod_gv   <= COEF_GV * v_ext;
      prod_bu   <= COEF_BU * u_ext;
    end
  end

  // Stages 3 and 4: channel sums, then clamp and pack, one unit per pixel.
  y2r_pixel #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_pixel_first (
    .clk      (clk),
    .en       (pix_en),
    .y_scaled (y0_scaled),
    .prod_rv  (prod_rv),
    .prod_gu  (prod_gu),
    .prod_gv  (prod_gv),
    .prod_bu  (prod_bu),
    .pixel    (pixel_first)
  );

  y2r_pixel #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_pixel_second (
    .clk      (clk),
    .en       (pix_en),
    .y_scaled (y1_scaled),
    .prod_rv  (prod_rv),
    .prod_gu  (prod_gu),
    .prod_gv  (prod_gv),
    .prod_bu  (prod_bu),
    .pixel    (pixel_second)
  );

endmodule

// ===== sv/y2r_pixel.sv =====
// One pixel's channel sums, clamp and RGB565 packing, two register stages.
// Depends on y2r_pkg.
module y2r_pixel #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                             clk,
  input  y2r_pkg::stage_en_t               en,
  input  logic signed [COEF_FRAC_BITS+10:0] y_scaled,
  input  logic signed [COEF_FRAC_BITS+10:0] prod_rv,
  input  logic signed [COEF_FRAC_BITS+10:0] prod_gu,
  input  logic signed [COEF_FRAC_BITS+10:0] prod_gv,
  input  logic signed [COEF_FRAC_BITS+10:0] prod_bu,
  output logic [15:0]                      pixel
);
  import y2r_pkg::*;

  localparam int ACC_W = COEF_FRAC_BITS + 11;

  logic signed [ACC_W-1:0] red_sum;
  logic signed [ACC_W-1:0] green_sum;
  logic signed [ACC_W-1:0] blue_sum;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  // Floor by dropping fraction bits, then clamp to 0..255.
  function automatic logic [7:0] clamp_chan(input logic signed [ACC_W-1:0] acc);
    logic [7:0] q;
    if (acc[ACC_W-1]) begin
      q = 8'h00;
    end else if (|acc[ACC_W-2:COEF_FRAC_BITS+8]) begin
      q = CHAN_MAX;
    end else begin
      q = acc[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
    end
    return q;
  endfunction

  always_ff @(posedge clk) begin
    if (en.sum_en) begin
      red_sum   <= y_scaled + prod_rv;
      green_sum <= y_scaled - prod_gu - prod_gv;
      blue_sum  <= y_scaled + prod_bu;
    end
  end

  always_comb begin
    red   = clamp_chan(red_sum);
    green = clamp_chan(green_sum);
    blue  = clamp_chan(blue_sum);
  end

  always_ff @(posedge clk) begin
    if (en.pack_en) begin
      pixel <= {red[7:3], green[7:2], blue[7:3]};
    end
  end

endmodule

// ===== sv/y2r_checker.sv =====
// Port-level checks for the YUY2 to RGB565 converter, bound to the top level.
// Depends on yuy2_to_rgb565_converter_assert.svh.
`include "yuy2_to_rgb565_converter_assert.svh"

module y2r_checker (
  input logic        clk,
  input logic        rst,
  input logic        yuv_valid,
  input logic        yuv_ready,
  input logic [7:0]  luma_first,
  input logic [7:0]  chroma_blue,
  input logic [7:0]  luma_second,
  input logic [7:0]  chroma_red,
  input logic        rgb_valid,
  input logic        rgb_ready,
  input logic [15:0] pixel_first,
  input logic [15:0] pixel_second
);

  // Hold a stalled result and its payload.
  `Y2R_ASSERT_NEXT(a_out_hold, clk, rst, rgb_valid && !rgb_ready,
    rgb_valid && $stable(pixel_first) && $stable(pixel_second),
    "stalled result changed")

  // Drop the output valid bit on reset.
  `Y2R_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !rgb_valid,
    "result valid right after reset")

  // An empty output stage means the whole pipeline can advance.
  `Y2R_ASSERT_IMPLY(a_ready_when_drained, clk, rst, !rgb_valid, yuv_ready,
    "input blocked with output stage empty")

endmodule

bind yuy2_to_rgb565_converter y2r_checker u_y2r_checker (.*);
